// ----- rtl/core/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generational handle allocator: port
// widths, operation codes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int IN_IDX_W   = 10;
  localparam int IN_GEN_W   = 16;
  localparam int OUT_CNT_W  = 11;

  localparam int SLOT_COUNT_DEF = 1024;
  localparam int GEN_BITS_DEF   = 16;

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QWAIT,
    S_GWAIT
  } state_t;

endpackage

// ----- rtl/core/gha_ram.sv -----
// ----------------------------------------------------------------------------
// gha_ram
// Single-clock memory with one write port and one read port; read data is
// registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out handles of slot index and generation; freed slots are reused in
// first-in first-out order through a free queue memory.
//
//   channel  ports                                     transfer when
//   input    in_kind, in_handle_index,                 start & !busy
//            in_handle_generation
//   result   out_ok, out_index, out_generation,        out_valid
//            out_live_count
//
// clear and a create that takes a never-used slot or is refused answer from
// the idle state; destroy and check wait on a read of the generation memory,
// and a create that reuses a freed slot reads the free queue memory and then
// the generation memory; each result is registered.
// busy is high while an operation waits on memory read data.
// no clearing pass after reset: slots above the used count are never live.
// the receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int GEN_BITS   = GEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_kind,
  input  logic [IN_IDX_W-1:0]  in_handle_index,
  input  logic [IN_GEN_W-1:0]  in_handle_generation,
  output logic                 out_valid,
  output logic                 out_ok,
  output logic [IN_IDX_W-1:0]  out_index,
  output logic [IN_GEN_W-1:0]  out_generation,
  output logic [OUT_CNT_W-1:0] out_live_count
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int RNG_W = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
  localparam int CMP_W = (GEN_BITS > IN_GEN_W) ? GEN_BITS : IN_GEN_W;
  localparam int ENT_W = GEN_BITS + 1;

  state_t               state_r, state_nxt;
  kind_t                kind_r, kind_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IN_GEN_W-1:0]  hgen_r, hgen_nxt;
  logic                 in_range_r, in_range_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [CNT_W-1:0]     free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]     live_r, live_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [IN_IDX_W-1:0]  out_index_r, out_index_nxt;
  logic [IN_GEN_W-1:0]  out_gen_r, out_gen_nxt;
  logic [OUT_CNT_W-1:0] out_live_r;

  logic                 g_we;
  logic [IDX_W-1:0]     g_waddr, g_raddr;
  logic [ENT_W-1:0]     g_wdata, g_rdata;
  logic                 q_we;
  logic [IDX_W-1:0]     q_waddr, q_raddr;
  logic [IDX_W-1:0]     q_wdata, q_rdata;

  logic [GEN_BITS-1:0]  cur_gen;
  logic                 cur_live;
  logic                 match;

  // generation memory entry: {live, generation}
  gha_ram #(.WIDTH(ENT_W), .DEPTH(SLOT_COUNT)) u_gen_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_free_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign cur_gen  = g_rdata[GEN_BITS-1:0];
  assign cur_live = g_rdata[GEN_BITS];
  assign match    = in_range_r && cur_live && (CMP_W'(cur_gen) == CMP_W'(hgen_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      free_cnt_r  <= '0;
      live_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      free_cnt_r  <= free_cnt_nxt;
      live_r      <= live_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    idx_r       <= idx_nxt;
    hgen_r      <= hgen_nxt;
    in_range_r  <= in_range_nxt;
    out_ok_r    <= out_ok_nxt;
    out_index_r <= out_index_nxt;
    out_gen_r   <= out_gen_nxt;
    out_live_r  <= OUT_CNT_W'(live_nxt);
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    hgen_nxt      = hgen_r;
    in_range_nxt  = in_range_r;
    used_nxt      = used_r;
    free_cnt_nxt  = free_cnt_r;
    live_nxt      = live_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = 1'b0;
    out_index_nxt = '0;
    out_gen_nxt   = '0;
    g_we          = 1'b0;
    g_waddr       = idx_r;
    g_wdata       = '0;
    g_raddr       = idx_r;
    q_we          = 1'b0;
    q_waddr       = tail_r;
    q_wdata       = idx_r;
    q_raddr       = head_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt     = kind_t'(in_kind);
          idx_nxt      = IDX_W'(in_handle_index);
          hgen_nxt     = in_handle_generation;
          in_range_nxt = RNG_W'(in_handle_index) < RNG_W'(used_r);
          case (kind_t'(in_kind))
            KIND_CREATE: begin
              if (free_cnt_r != '0) begin
                // pop the oldest freed slot
                q_raddr      = head_r;
                head_nxt     = (head_r == IDX_W'(SLOT_COUNT - 1)) ? '0 : head_r + 1'b1;
                state_nxt    = S_QWAIT;
              end else if (used_r < CNT_W'(SLOT_COUNT)) begin
                // fresh slot, generation zero
                g_we          = 1'b1;
                g_waddr       = IDX_W'(used_r);
                g_wdata       = {1'b1, {GEN_BITS{1'b0}}};
                used_nxt      = used_r + 1'b1;
                live_nxt      = live_r + 1'b1;
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b1;
                out_index_nxt = IN_IDX_W'(used_r);
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            KIND_DESTROY, KIND_CHECK: begin
              g_raddr   = IDX_W'(in_handle_index);
              state_nxt = S_GWAIT;
            end
            KIND_CLEAR: begin
              used_nxt      = '0;
              free_cnt_nxt  = '0;
              live_nxt      = '0;
              head_nxt      = '0;
              tail_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_ok_nxt    = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_QWAIT: begin
        idx_nxt   = q_rdata;
        g_raddr   = q_rdata;
        state_nxt = S_GWAIT;
      end
      S_GWAIT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (kind_r)
          KIND_CREATE: begin
            g_we          = 1'b1;
            g_wdata       = {1'b1, cur_gen};
            free_cnt_nxt  = free_cnt_r - 1'b1;
            live_nxt      = live_r + 1'b1;
            out_ok_nxt    = 1'b1;
            out_index_nxt = IN_IDX_W'(idx_r);
            out_gen_nxt   = IN_GEN_W'(cur_gen);
          end
          KIND_DESTROY: begin
            if (match) begin
              g_we         = 1'b1;
              g_wdata      = {1'b0, GEN_BITS'(cur_gen + 1'b1)};
              q_we         = 1'b1;
              tail_nxt     = (tail_r == IDX_W'(SLOT_COUNT - 1)) ? '0 : tail_r + 1'b1;
              free_cnt_nxt = free_cnt_r + 1'b1;
              live_nxt     = live_r - 1'b1;
              out_ok_nxt   = 1'b1;
            end
          end
          KIND_CHECK: begin
            out_ok_nxt = match;
          end
          default: begin
            out_ok_nxt = 1'b0;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_index      = out_index_r;
  assign out_generation = out_gen_r;
  assign out_live_count = out_live_r;

`ifndef SYNTHESIS
  // every slot handed out is either live or waiting in the free queue
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ((CNT_W + 1)'(free_cnt_r) + (CNT_W + 1)'(live_r)) == (CNT_W + 1)'(used_r))
    else $error("free and live counts do not add up to used slots");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while an operation is in flight");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_CLEAR) |=> (out_valid && out_ok &&
      out_live_count == '0))
    else $error("clear did not complete in one cycle");

  a_lookup_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_DESTROY || in_kind == KIND_CHECK))
      |=> (busy && !out_valid) ##1 out_valid)
    else $error("destroy or check result not two cycles after transfer");
`endif

endmodule
